[sv/tmf_pkg.sv]
// Shared types and constants for the tilt to motor frame block.
package tmf_pkg;

    localparam int ANGLE_W  = 13;
    localparam int CFG_W    = 13;
    localparam int DZ_W     = 10;
    localparam int GAIN_W   = 9;
    localparam int SPEED_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int MOTORS   = 4;
    localparam int IDX_W    = 4;
    localparam int REG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_BASE_X    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE_Y    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN      = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd26;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 9'd256;

    // Steep backward tilt threshold, 30 degrees
    localparam int BACK_LIMIT = 480;
    localparam logic [BYTE_W-1:0] IDLE_TARGET = 8'd120;

    // Frame characters
    localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_B      = 8'h42;
    localparam logic [BYTE_W-1:0] CHAR_C      = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_D      = 8'h44;
    localparam logic [BYTE_W-1:0] CHAR_F      = 8'h46;
    localparam logic [BYTE_W-1:0] NIBBLE_BASE = 8'd97;
    localparam logic [IDX_W-1:0]  LAST_IDX    = 4'd12;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] base_x;
        logic signed [ANGLE_W-1:0] base_y;
        logic [DZ_W-1:0]           dead_zone;
        logic [GAIN_W-1:0]         gain;
    } cfg_t;

    // Integer parts of the four smoothed speeds, motor A at index 0
    typedef logic [MOTORS-1:0][BYTE_W-1:0] frame_t;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_HALT,
        DRV_FWD,
        DRV_LEFT,
        DRV_RIGHT,
        DRV_FWD_LEFT,
        DRV_FWD_RIGHT
    } drive_t;

endpackage

[sv/tilt_to_motor_frame.sv]
// Top level: configuration registers, front end, frame queue and serialiser.
//
//  channel   handshake          payload
//  input     push / full        angle_x, angle_y
//  result    pop / empty        char_code, last_char
//  config    cfg_we             cfg_index, cfg_data
//
// Each input word yields thirteen result words, one a cycle while pop is held, so
// the output sets the rate; the front end captures the deltas, takes the quotients,
// classifies, runs each motor in turn through the filter multiplier and hands over to the queue.
// Reset clears control state, the motor targets and speeds; gain resets to 26.
// The two-entry frame queue lets the front end take a new word while a stalled
// result side is still draining the previous frame.
module tilt_to_motor_frame
    import tmf_pkg::*;
#(
    parameter int TILT_LIMIT = 720
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [ANGLE_W-1:0]   angle_x,
    input  logic signed [ANGLE_W-1:0]   angle_y,
    output logic                        empty,
    input  logic                        pop,
    output logic [BYTE_W-1:0]           char_code,
    output logic                        last_char,
    input  logic                        cfg_we,
    input  logic [REG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data
);

    cfg_t   cfg_reg;
    frame_t front_frame;
    frame_t head;
    logic   front_valid;
    logic   fifo_not_full;
    logic   fifo_not_empty;
    logic   head_pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_x    <= '0;
            cfg_reg.base_y    <= '0;
            cfg_reg.dead_zone <= '0;
            cfg_reg.gain      <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_X:    cfg_reg.base_x    <= cfg_data;
                REG_BASE_Y:    cfg_reg.base_y    <= cfg_data;
                REG_DEAD_ZONE: cfg_reg.dead_zone <= cfg_data[DZ_W-1:0];
                REG_GAIN:      cfg_reg.gain      <= cfg_data[GAIN_W-1:0];
                default:       cfg_reg.gain      <= cfg_reg.gain;
            endcase
        end
    end

    tmf_front #(
        .TILT_LIMIT (TILT_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .angle_x     (angle_x),
        .angle_y     (angle_y),
        .frame       (front_frame),
        .frame_valid (front_valid),
        .frame_ready (fifo_not_full)
    );

    tmf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_valid),
        .wr_data   (front_frame),
        .not_full  (fifo_not_full),
        .rd_en     (head_pop),
        .rd_data   (head),
        .not_empty (fifo_not_empty)
    );

    tmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (fifo_not_empty),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .char_code  (char_code),
        .last_char  (last_char)
    );

endmodule

[sv/tmf_front.sv]
// Front end: takes tilt words, derives drive targets and smooths the motor speeds.
module tmf_front
    import tmf_pkg::*;
#(
    parameter int TILT_LIMIT = 720
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      push,
    output logic                      full,
    input  logic signed [ANGLE_W-1:0] angle_x,
    input  logic signed [ANGLE_W-1:0] angle_y,
    output frame_t                    frame,
    output logic                      frame_valid,
    input  logic                      frame_ready
);

    localparam int MAG_W    = $clog2(TILT_LIMIT + 1);
    localparam int NUM_W    = MAG_W + BYTE_W;
    localparam int DIFF_W   = ANGLE_W + 1;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int PROD_W   = ERR_W + GAIN_W + 1;
    localparam int RECIP_SH = NUM_W + MAG_W;
    localparam int RECIP_W  = NUM_W + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(TILT_LIMIT) - 64'd1) / 64'(TILT_LIMIT));

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_CLASS  = 5'b00100,
        S_SMOOTH = 5'b01000,
        S_PUSH   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]             mot_reg;
    logic [NUM_W-1:0]       rem_f_reg, rem_s_reg;
    logic [BYTE_W-1:0]      q_f_reg, q_s_reg;
    logic                   dx_neg_reg;
    logic                   bk_reg;
    logic [BYTE_W-1:0]      targets_reg [MOTORS];
    logic [BYTE_W-1:0]      targets_next [MOTORS];
    logic [SPEED_W-1:0]     speeds_reg [MOTORS];

    logic signed [DIFF_W-1:0]    diff_x, diff_y;
    logic [MAG_W:0]              fit_x, fit_y;
    logic [NUM_W+RECIP_W-1:0]    recip_f, recip_s;
    drive_t                      drive;
    logic [BYTE_W-1:0]           half_f;
    logic [BYTE_W:0]             mix_sum;
    logic [GAIN_W-1:0]           gain_sat;
    logic [BYTE_W-1:0]           tgt;
    logic [SPEED_W-1:0]          spd;
    logic signed [ERR_W-1:0]     err;
    logic signed [PROD_W-1:0]    prod;

    // Clamp a delta to the tilt limit and zero it inside the dead zone.
    // Returns the sign and the magnitude.
    function automatic logic [MAG_W:0] fit_delta(input logic signed [DIFF_W-1:0] d,
                                                 input logic [DZ_W-1:0] dz);
        logic              neg;
        logic [DIFF_W-1:0] mag;
        logic [MAG_W-1:0]  lim;
        neg = d[DIFF_W-1];
        mag = neg ? DIFF_W'(-d) : DIFF_W'(d);
        if (mag > DIFF_W'(TILT_LIMIT))
            lim = MAG_W'(TILT_LIMIT);
        else
            lim = mag[MAG_W-1:0];
        if (DIFF_W'(lim) < DIFF_W'(dz))
            lim = '0;
        if (lim == '0)
            neg = 1'b0;
        return {neg, lim};
    endfunction

    // Deltas against the base angles
    assign diff_x = DIFF_W'(angle_x) - DIFF_W'(cfg.base_x);
    assign diff_y = DIFF_W'(angle_y) - DIFF_W'(cfg.base_y);
    assign fit_x  = fit_delta(diff_x, cfg.dead_zone);
    assign fit_y  = fit_delta(diff_y, cfg.dead_zone);

    // Quotients by the tilt limit: multiply by the rounded-up reciprocal,
    // exact over the whole numerator range
    assign recip_f = rem_f_reg * RECIP;
    assign recip_s = rem_s_reg * RECIP;

    // Classify the drive state
    always_comb
    begin
        if (bk_reg)
            drive = DRV_HALT;
        else if (q_f_reg == '0 && q_s_reg == '0)
            drive = DRV_IDLE;
        else if (q_s_reg == '0)
            drive = DRV_FWD;
        else if (q_f_reg == '0)
            drive = dx_neg_reg ? DRV_LEFT : DRV_RIGHT;
        else
            drive = dx_neg_reg ? DRV_FWD_LEFT : DRV_FWD_RIGHT;
    end

    assign half_f  = q_f_reg >> 1;
    assign mix_sum = (BYTE_W + 1)'(q_f_reg) + (BYTE_W + 1)'(q_s_reg);

    // Update the held targets for the chosen state
    always_comb
    begin
        targets_next = targets_reg;
        case (drive)
            DRV_HALT:
            begin
                for (int m = 0; m < MOTORS; m++)
                    targets_next[m] = '0;
            end
            DRV_FWD:
            begin
                targets_next[0] = q_f_reg;
                targets_next[1] = q_f_reg;
            end
            DRV_LEFT:
                targets_next[1] = q_s_reg;
            DRV_RIGHT:
                targets_next[0] = q_s_reg;
            DRV_FWD_LEFT:
            begin
                targets_next[0] = half_f;
                targets_next[1] = mix_sum[BYTE_W:1];
            end
            DRV_FWD_RIGHT:
            begin
                targets_next[1] = half_f;
                targets_next[0] = mix_sum[BYTE_W:1];
            end
            default:
            begin
                targets_next[2] = IDLE_TARGET;
                targets_next[3] = IDLE_TARGET;
            end
        endcase
    end

    // Exponential filter, one motor a cycle: speed + gain * (target - speed) / 256
    assign gain_sat = (cfg.gain > GAIN_MAX) ? GAIN_MAX : cfg.gain;
    assign tgt  = targets_reg[mot_reg];
    assign spd  = speeds_reg[mot_reg];
    assign err  = $signed({1'b0, tgt, {BYTE_W{1'b0}}}) - $signed({1'b0, spd});
    assign prod = $signed({1'b0, gain_sat}) * err;

    // Sequence one word through division, classification and smoothing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (push)
                    state_next = S_DIV;
            S_DIV:
                state_next = S_CLASS;
            S_CLASS:
                state_next = S_SMOOTH;
            S_SMOOTH:
                if (mot_reg == 2'(MOTORS - 1))
                    state_next = S_PUSH;
            S_PUSH:
                if (frame_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mot_reg   <= '0;
            for (int m = 0; m < MOTORS; m++)
            begin
                targets_reg[m] <= '0;
                speeds_reg[m]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                    mot_reg <= '0;
                S_CLASS:
                    targets_reg <= targets_next;
                S_SMOOTH:
                begin
                    speeds_reg[mot_reg] <= spd + prod[SPEED_W+BYTE_W-1:BYTE_W];
                    mot_reg <= mot_reg + 2'd1;
                end
                default:
                    mot_reg <= '0;
            endcase
        end
    end

    // Capture deltas, then take the quotients
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && push)
        begin
            dx_neg_reg <= fit_x[MAG_W];
            bk_reg     <= fit_y[MAG_W] && (DIFF_W'(fit_y[MAG_W-1:0]) >= DIFF_W'(BACK_LIMIT));
            if (fit_y[MAG_W])
            begin
                rem_f_reg <= '0;
                rem_s_reg <= '0;
            end
            else
            begin
                rem_f_reg <= {fit_y[MAG_W-1:0], {BYTE_W{1'b0}}} - NUM_W'(fit_y[MAG_W-1:0]);
                rem_s_reg <= {fit_x[MAG_W-1:0], {BYTE_W{1'b0}}} - NUM_W'(fit_x[MAG_W-1:0]);
            end
        end
        else if (state_reg == S_DIV)
        begin
            q_f_reg <= recip_f[RECIP_SH +: BYTE_W];
            q_s_reg <= recip_s[RECIP_SH +: BYTE_W];
        end
    end

    // Hand the integer speeds to the queue
    always_comb
    begin
        for (int m = 0; m < MOTORS; m++)
            frame[m] = speeds_reg[m][SPEED_W-1:BYTE_W];
    end

    assign frame_valid = (state_reg == S_PUSH);
    assign full        = (state_reg != S_IDLE);

endmodule

[sv/tmf_fifo.sv]
// Two-entry queue of speed frames between the front end and the serialiser.
module tmf_fifo
    import tmf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  frame_t wr_data,
    output logic   not_full,
    input  logic   rd_en,
    output frame_t rd_data,
    output logic   not_empty
);

    frame_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr, do_rd;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_wr     = wr_en && not_full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[sv/tmf_back.sv]
// Serialiser: turns each speed frame into thirteen characters behind an output register.
module tmf_back
    import tmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frame_t            head,
    input  logic              head_valid,
    output logic              head_pop,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] char_code,
    output logic              last_char
);

    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] char_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] char_next;
    logic              load;

    // Pick the character for the current position
    always_comb
    begin
        case (idx_reg)
            4'd0:    char_next = CHAR_A;
            4'd1:    char_next = NIBBLE_BASE + BYTE_W'(head[0][7:4]);
            4'd2:    char_next = NIBBLE_BASE + BYTE_W'(head[0][3:0]);
            4'd3:    char_next = CHAR_B;
            4'd4:    char_next = NIBBLE_BASE + BYTE_W'(head[1][7:4]);
            4'd5:    char_next = NIBBLE_BASE + BYTE_W'(head[1][3:0]);
            4'd6:    char_next = CHAR_C;
            4'd7:    char_next = NIBBLE_BASE + BYTE_W'(head[2][7:4]);
            4'd8:    char_next = NIBBLE_BASE + BYTE_W'(head[2][3:0]);
            4'd9:    char_next = CHAR_D;
            4'd10:   char_next = NIBBLE_BASE + BYTE_W'(head[3][7:4]);
            4'd11:   char_next = NIBBLE_BASE + BYTE_W'(head[3][3:0]);
            default: char_next = CHAR_F;
        endcase
    end

    assign load     = head_valid && (!out_valid_reg || pop);
    assign head_pop = load && (idx_reg == LAST_IDX);

    // Advance through the frame and hold the output word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 4'd1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= (idx_reg == LAST_IDX);
        end
    end

    assign empty     = !out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule
